// ----- hdl/ssvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Split-screen viewport table: shared definitions
// Field widths, command and register codes, word types and the grid tables
// that map a player count and a table slot onto a split-screen tile.
// ----------------------------------------------------------------------------
package ssvt_pkg;

    // Field widths fixed by the interface.
    localparam int DIM_W     = 14;
    localparam int ID_W      = 8;
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 3;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 1;

    // Default table depth.
    localparam int MAX_PLAYERS_DEFAULT = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
    localparam logic [DIM_W-1:0]     SCREEN_WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0]     SCREEN_HEIGHT_RST = 14'd1080;

    // Division by three as a multiply by ceil(2^16 / 3) and a shift; exact for
    // every 14-bit dividend.
    localparam int                 RECIP_W     = 15;
    localparam int                 RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_THIRD = 15'd21846;

    // Input word.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  player_id;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [DIM_W-1:0]  tile_x;
        logic [DIM_W-1:0]  tile_y;
        logic [DIM_W-1:0]  tile_width;
        logic [DIM_W-1:0]  tile_height;
        logic [CNT_W-1:0]  player_count;
    } out_word_t;

    // Tile rectangle handed back by the tile unit.
    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } tile_t;

    // Column count minus one for a given player count.
    function automatic logic [1:0] grid_cols_m1(input logic [CNT_W-1:0] n);
        logic [1:0] c;
        case (n)
            4'd0, 4'd1: c = 2'd0;
            4'd2:       c = 2'd1;
            4'd3:       c = 2'd2;
            4'd4:       c = 2'd1;
            4'd5, 4'd6: c = 2'd2;
            default:    c = 2'd3;
        endcase
        return c;
    endfunction

    // The grid has two rows from four players upwards.
    function automatic logic grid_two_rows(input logic [CNT_W-1:0] n);
        return (n >= 4'd4);
    endfunction

    // Column of a slot within the grid.
    function automatic logic [1:0] slot_col(input logic [SLOT_W-1:0] s,
                                            input logic [1:0] cols_m1);
        logic [1:0] c;
        case (cols_m1)
            2'd0:    c = 2'd0;
            2'd1:    c = {1'b0, s[0]};
            2'd2:    c = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
            default: c = s[1:0];
        endcase
        return c;
    endfunction

    // Row of a slot within the grid; only the top two rows ever occur.
    function automatic logic slot_row(input logic [SLOT_W-1:0] s,
                                      input logic [1:0] cols_m1);
        logic r;
        case (cols_m1)
            2'd0:    r = 1'b0;
            2'd1:    r = s[1];
            2'd2:    r = (s >= 3'd3);
            default: r = s[2];
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/ssvt_tile_unit.sv -----
// ----------------------------------------------------------------------------
// Split-screen viewport table: tile unit
// Two-step unit that turns a player count and a slot into the tile
// rectangle: first the column width and row height, then origin and size.
// ----------------------------------------------------------------------------
module ssvt_tile_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ssvt_pkg::DIM_W-1:0]    screen_width,
    input  logic [ssvt_pkg::DIM_W-1:0]    screen_height,
    input  logic [ssvt_pkg::CNT_W-1:0]    player_count,
    input  logic [ssvt_pkg::SLOT_W-1:0]   slot,
    output logic                          done,
    output ssvt_pkg::tile_t               tile
);

    localparam int PROD_W = ssvt_pkg::DIM_W + ssvt_pkg::RECIP_W;
    localparam int SPAN_W = ssvt_pkg::DIM_W + 2;

    logic [1:0]                 cols_m1;
    logic [PROD_W-1:0]          third_prod;
    logic [ssvt_pkg::DIM_W-1:0] cw_next;
    logic [ssvt_pkg::DIM_W-1:0] rh_next;

    logic                       step_reg;
    logic                       done_reg;
    logic [ssvt_pkg::DIM_W-1:0] cw_reg;
    logic [ssvt_pkg::DIM_W-1:0] rh_reg;
    logic [1:0]                 cols_m1_reg;
    logic [1:0]                 col_reg;
    logic                       row_reg;
    logic                       two_rows_reg;

    logic [SPAN_W-1:0]          x_prod;
    logic [SPAN_W-1:0]          span_prod;
    ssvt_pkg::tile_t            tile_next;
    ssvt_pkg::tile_t            tile_reg;

    // First step: column width and row height.
    assign cols_m1    = ssvt_pkg::grid_cols_m1(player_count);
    assign third_prod = {{ssvt_pkg::RECIP_W{1'b0}}, screen_width}
                        * {{ssvt_pkg::DIM_W{1'b0}}, ssvt_pkg::RECIP_THIRD};

    always_comb begin
        case (cols_m1)
            2'd0:    cw_next = screen_width;
            2'd1:    cw_next = screen_width >> 1;
            2'd2:    cw_next = {1'b0, third_prod[ssvt_pkg::RECIP_SHIFT +: ssvt_pkg::DIM_W-1]};
            default: cw_next = screen_width >> 2;
        endcase
        rh_next = ssvt_pkg::grid_two_rows(player_count) ? (screen_height >> 1)
                                                         : screen_height;
    end

    // Second step: origin, and the remainder for the last column and row.
    assign x_prod    = SPAN_W'(col_reg) * SPAN_W'(cw_reg);
    assign span_prod = SPAN_W'(cols_m1_reg) * SPAN_W'(cw_reg);

    always_comb begin
        tile_next.x     = x_prod[ssvt_pkg::DIM_W-1:0];
        tile_next.y     = row_reg ? rh_reg : '0;
        tile_next.width = (col_reg == cols_m1_reg)
                          ? screen_width - span_prod[ssvt_pkg::DIM_W-1:0] : cw_reg;
        if (!two_rows_reg) begin
            tile_next.height = screen_height;
        end else if (row_reg) begin
            tile_next.height = screen_height - rh_reg;
        end else begin
            tile_next.height = rh_reg;
        end
    end

    // Step registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= start;
            done_reg <= step_reg;
        end
        if (start) begin
            cw_reg       <= cw_next;
            rh_reg       <= rh_next;
            cols_m1_reg  <= cols_m1;
            col_reg      <= ssvt_pkg::slot_col(slot, cols_m1);
            row_reg      <= ssvt_pkg::slot_row(slot, cols_m1);
            two_rows_reg <= ssvt_pkg::grid_two_rows(player_count);
        end
        if (step_reg) begin
            tile_reg <= tile_next;
        end
    end

    assign done = done_reg;
    assign tile = tile_reg;

endmodule

// ----- hdl/split_screen_viewport_table.sv -----
// ----------------------------------------------------------------------------
// Split-screen viewport table
// Ordered table of player ids sharing one screen, with add, remove and
// tile lookup; a lookup returns the player's tile of the split-screen grid.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Word
//   s_        in         s_valid / s_ready    command, player_id
//   m_        out        m_valid / m_ready    ok, slot, tile, player_count
//   cfg_      in         cfg_wr_en            screen_width, screen_height
//
// The time an item takes depends on the player count: it is set by the scan
// of the table, one entry a cycle through its single read port, by the
// removal shift, one entry a cycle, and, for a lookup, by the two steps of
// the tile unit. Reset is synchronous and empties the table at once. A
// result waits in the output register while the next word is taken; a
// finished item holds there only if that register is still full.
//
module split_screen_viewport_table #(
    parameter int MAX_PLAYERS = ssvt_pkg::MAX_PLAYERS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ssvt_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ssvt_pkg::out_word_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [ssvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssvt_pkg::DIM_W-1:0]      cfg_wdata
);

    localparam int IDX_W = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
    localparam int CNT_W = ssvt_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_TILE,
        ST_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    logic [ssvt_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ssvt_pkg::ID_W-1:0]      id_reg, id_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic                           found_reg, found_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    ssvt_pkg::out_word_t            res_reg, res_next;
    ssvt_pkg::out_word_t            out_reg, out_next;
    logic                           m_valid_reg, m_valid_next;

    logic [ssvt_pkg::DIM_W-1:0]     screen_width_reg;
    logic [ssvt_pkg::DIM_W-1:0]     screen_height_reg;

    logic [ssvt_pkg::ID_W-1:0]      table_mem [MAX_PLAYERS];
    logic [ssvt_pkg::ID_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]               rd_addr;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [ssvt_pkg::ID_W-1:0]      mem_wdata;

    logic [CNT_W-1:0]               idx_inc;
    logic [CNT_W-1:0]               idx_inc2;
    logic                           tile_start;
    logic                           tile_done;
    ssvt_pkg::tile_t                tile;

    // Tile arithmetic.
    ssvt_tile_unit u_tile (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (tile_start),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .player_count  (count_reg),
        .slot          (ssvt_pkg::SLOT_W'(idx_reg)),
        .done          (tile_done),
        .tile          (tile)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= ssvt_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= ssvt_pkg::SCREEN_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssvt_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                ssvt_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Player table: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_inc2 = CNT_W'(idx_reg) + CNT_W'(2);

    // Sequencer: scan, then update the table or start the tile unit.
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = rd_data_reg;
        rd_addr      = idx_inc[IDX_W-1:0];
        tile_start   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                rd_addr = '0;
                if (s_valid) begin
                    cmd_next   = s_data.command;
                    id_next    = s_data.player_id;
                    idx_next   = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The read issued here fetches the entry after a match, which
                // a removal needs first.
                if (rd_data_reg == id_reg) begin
                    found_next = 1'b1;
                    state_next = ST_DECIDE;
                end else if (idx_inc < count_reg) begin
                    idx_next = idx_inc[IDX_W-1:0];
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_FINISH;
                case (cmd_reg)
                    ssvt_pkg::CMD_ADD: begin
                        if (!found_reg && count_reg < CNT_W'(MAX_PLAYERS)) begin
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[IDX_W-1:0];
                            mem_wdata   = id_reg;
                            count_next  = count_reg + CNT_W'(1);
                            res_next.ok = 1'b1;
                        end
                    end
                    ssvt_pkg::CMD_REMOVE: begin
                        if (found_reg) begin
                            res_next.ok = 1'b1;
                            if (idx_inc < count_reg) begin
                                state_next = ST_SHIFT;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    ssvt_pkg::CMD_LOOKUP: begin
                        if (found_reg) begin
                            tile_start    = 1'b1;
                            res_next.ok   = 1'b1;
                            res_next.slot = ssvt_pkg::SLOT_W'(idx_reg);
                            state_next    = ST_TILE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SHIFT: begin
                // Move the next entry down by one place.
                mem_we  = 1'b1;
                rd_addr = idx_inc2[IDX_W-1:0];
                if (idx_inc2 < count_reg) begin
                    idx_next = idx_inc[IDX_W-1:0];
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_FINISH;
                end
            end
            ST_TILE: begin
                if (tile_done) begin
                    res_next.tile_x      = tile.x;
                    res_next.tile_y      = tile.y;
                    res_next.tile_width  = tile.width;
                    res_next.tile_height = tile.height;
                    state_next           = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next              = res_reg;
                    out_next.player_count = count_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg <= cmd_next;
        id_reg  <= id_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    // The table never holds more players than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PLAYERS))
        else $error("player count exceeds table depth");

    // Only an add or a removal step changes the player count.
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == ST_DECIDE || $past(state_reg) == ST_SHIFT))
        else $error("player count changed outside an update step");

    // A refused or missed operation reports no tile.
    a_fail_no_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ok) |->
            (m_data.slot == '0 && m_data.tile_x == '0 && m_data.tile_y == '0 &&
             m_data.tile_width == '0 && m_data.tile_height == '0))
        else $error("failed operation reports a tile");

    // The block is not ready again in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");
`endif

endmodule
